// ===== rtl/qrt_pkg.sv =====
// Shared types and constants for the Q-routing next-hop table.
// Used by qrt_qmem, qrt_blend and the top level; depends on nothing else.
package qrt_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int ID_W          = 6;
    localparam int COST_W        = 32;
    localparam int QADDR_W       = 2 * ID_W;
    localparam int QWORD_W       = COST_W + 1;

    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_HELLO    = 3'd1;
    localparam logic [2:0] REQ_DATA     = 3'd2;
    localparam logic [2:0] REQ_FEEDBACK = 3'd3;
    localparam logic [2:0] REQ_DROP     = 3'd4;
    localparam logic [2:0] REQ_SEND     = 3'd5;

    localparam logic [2:0] CFG_MY_ID   = 3'd0;
    localparam logic [2:0] CFG_ALPHA   = 3'd1;
    localparam logic [2:0] CFG_EPSILON = 3'd2;
    localparam logic [2:0] CFG_INIT_Q  = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT = 3'd4;
    localparam logic [2:0] CFG_PENALTY = 3'd5;

    // q table access from the sequencer; word is {known, cost}
    typedef struct packed {
        logic               rd_en;
        logic [QADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [QADDR_W-1:0] wr_addr;
        logic [QWORD_W-1:0] wr_data;
    } qmem_req_t;

endpackage

// ===== rtl/qrt_qmem.sv =====
// Cost table memory with known bit per entry and a clearing pass after reset.
// Depends on qrt_pkg.
module qrt_qmem
    import qrt_pkg::*;
#(
    parameter int NW = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  qmem_req_t          req,
    output logic [QWORD_W-1:0] rd_data,
    output logic               busy
);

    localparam int QAW = 2 * NW;
    localparam int QD  = 1 << QAW;

    logic [QWORD_W-1:0] mem [QD];
    logic [QAW-1:0]     clr_cnt_reg;
    logic               clr_run_reg;
    logic [QWORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            clr_run_reg <= 1'b1;
        end
        else if (clr_run_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
                clr_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_run_reg)
            mem[clr_cnt_reg] <= '0;
        else if (req.wr_en)
            mem[req.wr_addr[QAW-1:0]] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr[QAW-1:0]];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_run_reg;

endmodule

// ===== rtl/qrt_ram.sv =====
// Simple one-write one-read synchronous RAM, registered read.
// Depends on nothing.
module qrt_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/qrt_blend.sv =====
// Smoothing update old*(1-a) + reward*a with rounding and saturation.
// Depends on qrt_pkg.
module qrt_blend
    import qrt_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic [COST_W-1:0] old_cost,
    input  logic [COST_W:0]   reward,
    input  logic [16:0]       alpha,
    output logic [COST_W-1:0] result
);

    logic [16:0] a;
    logic [16:0] inv_a;
    logic [48:0] p0_reg;
    logic [49:0] p1_reg;
    logic [50:0] sum;
    logic [34:0] shifted;

    // alpha above one acts as one
    assign a     = (alpha > 17'd65536) ? 17'd65536 : alpha;
    assign inv_a = 17'd65536 - a;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p0_reg <= old_cost * inv_a;
            p1_reg <= reward * a;
        end
    end

    assign sum     = 51'(p0_reg) + 51'(p1_reg) + 51'd32768;
    assign shifted = sum[50:16];
    assign result  = (|shifted[34:32]) ? '1 : shifted[31:0];

endmodule

// ===== rtl/q_routing_next_hop_table.sv =====
// Q-routing next-hop table engine, top level.
// Event beats arrive on s_*; one result beat per event leaves on m_*.
// Registers are written on cfg_* (always ready); the user must write them
// only while the engine is idle, the block does not enforce it.
// Depends on qrt_pkg, qrt_qmem, qrt_ram, qrt_blend.
// Usage: each s_* beat carries one event (kind on s_tuser). The engine works
// one event at a time and returns exactly one m_* beat for it.
// Steps per event, N = node count (64 by default):
//   hello, ignored events, data for this node: accept, then result
//   feedback / drop learning: read, multiply, write back, result
//   tick: the last-heard RAM scan over N neighbors, one neighbor a cycle
//   data forward / local send: the cost-table scan, then the remainder
//   unit and the pick walk when exploring.
// The scan through the cost RAM (one read port, one entry a cycle) sets the rate.
// After reset the cost table is swept to unknown; s_tready stays low
// meanwhile, cfg writes are taken as usual.
// The result sits in an output register: if the receiver stalls, the next
// event is still accepted and worked, and only its completion waits.
module q_routing_next_hop_table
    import qrt_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // node_id, dest, addressed_to, link_delay, min_q_next, rand_explore, rand_pick
    input  logic [103:0] s_tdata,
    // req_type
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // fb_target, fb_dest, fb_delay, fb_min_q, fwd_next_hop, zero pad
    output logic [87:0]  m_tdata,
    // fb_valid, delivered, fwd_valid, dropped
    output logic [3:0]   m_tuser
);

    localparam int NN = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int NW = $clog2(NN);
    localparam int CW = $clog2(NN + 1);
    localparam logic [ID_W:0] NN_ID = (ID_W + 1)'(NN);
    localparam logic [NW:0]   NN_SC = (NW + 1)'(NN);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_TSCAN = 9'b000000010,
        ST_FSCAN = 9'b000000100,
        ST_MOD   = 9'b000001000,
        ST_PICK  = 9'b000010000,
        ST_LRD   = 9'b000100000,
        ST_LMUL  = 9'b001000000,
        ST_LWR   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [ID_W-1:0]   my_id_reg;
    logic [16:0]       alpha_reg;
    logic [16:0]       eps_reg;
    logic [COST_W-1:0] initq_reg;
    logic [15:0]       tmo_reg;
    logic [COST_W-1:0] pen_reg;

    logic [ID_W-1:0]   node_reg;
    logic [ID_W-1:0]   dest_reg;
    logic [COST_W:0]   reward_reg;
    logic [15:0]       re_reg;
    logic [ID_W-1:0]   rp_sh_reg;
    logic              d_ok_reg;

    logic [15:0]       now_reg;
    logic [NN-1:0]     present_reg;

    logic [NW:0]       scan_cnt_reg;
    logic              rd_vld_reg;
    logic [NW-1:0]     rd_idx_reg;
    logic [COST_W-1:0] minq_reg;
    logic              any_reg;
    logic [COST_W-1:0] best_v_reg;
    logic [NW-1:0]     best_id_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     rem_reg;
    logic [2:0]        mstep_reg;
    logic [CW-1:0]     k_reg;
    logic [NW-1:0]     pick_idx_reg;

    logic              res_fbv_reg;
    logic [ID_W-1:0]   res_target_reg;
    logic [ID_W-1:0]   res_dest_reg;
    logic [COST_W-1:0] res_delay_reg;
    logic [COST_W-1:0] res_minq_reg;
    logic              res_del_reg;
    logic              res_fwd_reg;
    logic [ID_W-1:0]   res_hop_reg;
    logic              res_drop_reg;

    logic              m_tvalid_reg;
    logic [87:0]       m_tdata_reg;
    logic [3:0]        m_tuser_reg;

    // input beat fields
    logic [2:0]        in_type;
    logic [ID_W-1:0]   in_node;
    logic [ID_W-1:0]   in_dest;
    logic [ID_W-1:0]   in_to;
    logic [COST_W-1:0] in_delay;
    logic [COST_W-1:0] in_mq;
    logic [15:0]       in_re;
    logic [ID_W-1:0]   in_rp;

    assign in_type  = s_tuser;
    assign in_node  = s_tdata[5:0];
    assign in_dest  = s_tdata[11:6];
    assign in_to    = s_tdata[17:12];
    assign in_delay = s_tdata[49:18];
    assign in_mq    = s_tdata[81:50];
    assign in_re    = s_tdata[97:82];
    assign in_rp    = s_tdata[103:98];

    qmem_req_t         qreq;
    logic [QWORD_W-1:0] q_rd;
    logic              q_busy;
    logic              lh_we;
    logic [15:0]       lh_rd;
    logic [COST_W-1:0] blend_res;
    logic              blend_load;
    logic [COST_W-1:0] old_cost;

    logic              accept;
    logic              in_node_ok;
    logic              in_dest_ok;
    logic              scan_issue;
    logic              scan_end;
    logic              rd_known;
    logic [COST_W-1:0] rd_v;
    logic              out_load;
    logic [CW:0]       mod_tmp;
    logic [CW-1:0]     rem_next;
    logic [15:0]       age;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == ST_IDLE) && !q_busy;
    assign accept     = s_tvalid && s_tready;
    assign in_node_ok = {1'b0, in_node} < NN_ID;
    assign in_dest_ok = {1'b0, in_dest} < NN_ID;
    assign scan_issue = ((state_reg == ST_FSCAN) || (state_reg == ST_TSCAN))
                        && (scan_cnt_reg < NN_SC);
    assign scan_end   = (scan_cnt_reg == NN_SC) && !rd_vld_reg;
    assign rd_known   = d_ok_reg && q_rd[COST_W];
    assign rd_v       = rd_known ? q_rd[COST_W-1:0] : initq_reg;
    assign out_load   = !m_tvalid_reg || m_tready;
    assign age        = now_reg - lh_rd;

    // one restoring step of rand_pick mod count, msb first
    assign mod_tmp    = {rem_reg, rp_sh_reg[ID_W-1]};
    assign rem_next   = (mod_tmp >= {1'b0, cnt_reg}) ? CW'(mod_tmp - {1'b0, cnt_reg})
                                                     : mod_tmp[CW-1:0];

    always_comb
    begin
        qreq.rd_en   = (state_reg == ST_FSCAN && scan_issue) || (state_reg == ST_LRD);
        qreq.rd_addr = (state_reg == ST_FSCAN)
                       ? QADDR_W'({dest_reg[NW-1:0], scan_cnt_reg[NW-1:0]})
                       : QADDR_W'({dest_reg[NW-1:0], node_reg[NW-1:0]});
        qreq.wr_en   = (state_reg == ST_LWR);
        qreq.wr_addr = QADDR_W'({dest_reg[NW-1:0], node_reg[NW-1:0]});
        qreq.wr_data = {1'b1, blend_res};
    end

    assign lh_we      = accept && in_node_ok
                        && ((in_type == REQ_HELLO)
                            || (in_type == REQ_DATA
                                && (in_to == my_id_reg || in_dest == my_id_reg))
                            || (in_type == REQ_FEEDBACK && in_to == my_id_reg));
    assign blend_load = (state_reg == ST_LMUL);
    assign old_cost   = q_rd[COST_W] ? q_rd[COST_W-1:0] : initq_reg;

    qrt_qmem #(
        .NW (NW)
    ) u_qmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (qreq),
        .rd_data (q_rd),
        .busy    (q_busy)
    );

    qrt_ram #(
        .W     (16),
        .DEPTH (NN)
    ) u_lh_ram (
        .clk   (clk),
        .we    (lh_we),
        .waddr (in_node[NW-1:0]),
        .wdata (now_reg),
        .raddr (scan_cnt_reg[NW-1:0]),
        .rdata (lh_rd)
    );

    qrt_blend u_blend (
        .clk      (clk),
        .load     (blend_load),
        .old_cost (old_cost),
        .reward   (reward_reg),
        .alpha    (alpha_reg),
        .result   (blend_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_id_reg <= '0;
            alpha_reg <= 17'd32768;
            eps_reg   <= 17'd6554;
            initq_reg <= 32'd1000;
            tmo_reg   <= 16'd3;
            pen_reg   <= 32'd2000000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MY_ID:   my_id_reg <= cfg_data[ID_W-1:0];
                CFG_ALPHA:   alpha_reg <= cfg_data[16:0];
                CFG_EPSILON: eps_reg   <= cfg_data[16:0];
                CFG_INIT_Q:  initq_reg <= cfg_data;
                CFG_TIMEOUT: tmo_reg   <= cfg_data[15:0];
                CFG_PENALTY: pen_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // payload of the item in work
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            node_reg   <= in_node;
            dest_reg   <= in_dest;
            reward_reg <= (in_type == REQ_DROP) ? {1'b0, pen_reg}
                                                : ({1'b0, in_delay} + {1'b0, in_mq});
            re_reg     <= in_re;
            rp_sh_reg  <= in_rp;
            d_ok_reg   <= in_dest_ok;
        end
        else if (state_reg == ST_MOD)
        begin
            rp_sh_reg <= {rp_sh_reg[ID_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            present_reg    <= '0;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            minq_reg       <= '0;
            any_reg        <= 1'b0;
            best_v_reg     <= '0;
            best_id_reg    <= '0;
            cnt_reg        <= '0;
            rem_reg        <= '0;
            mstep_reg      <= '0;
            k_reg          <= '0;
            pick_idx_reg   <= '0;
            res_fbv_reg    <= 1'b0;
            res_target_reg <= '0;
            res_dest_reg   <= '0;
            res_delay_reg  <= '0;
            res_minq_reg   <= '0;
            res_del_reg    <= 1'b0;
            res_fwd_reg    <= 1'b0;
            res_hop_reg    <= '0;
            res_drop_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
                m_tvalid_reg <= 1'b0;

            rd_vld_reg <= scan_issue;
            rd_idx_reg <= scan_cnt_reg[NW-1:0];
            if (scan_issue)
                scan_cnt_reg <= scan_cnt_reg + 1'b1;

            if (lh_we)
                present_reg[in_node[NW-1:0]] <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_fbv_reg    <= 1'b0;
                        res_target_reg <= '0;
                        res_dest_reg   <= '0;
                        res_delay_reg  <= '0;
                        res_minq_reg   <= '0;
                        res_del_reg    <= 1'b0;
                        res_fwd_reg    <= 1'b0;
                        res_hop_reg    <= '0;
                        res_drop_reg   <= 1'b0;
                        scan_cnt_reg   <= '0;
                        minq_reg       <= initq_reg;
                        any_reg        <= 1'b0;
                        best_v_reg     <= '0;
                        best_id_reg    <= '0;
                        cnt_reg        <= '0;
                        state_reg      <= ST_DONE;
                        case (in_type)
                            REQ_TICK:
                            begin
                                now_reg   <= now_reg + 1'b1;
                                state_reg <= ST_TSCAN;
                            end
                            REQ_DATA:
                            begin
                                if (in_to != my_id_reg && in_dest != my_id_reg)
                                    res_drop_reg <= 1'b1;
                                else
                                begin
                                    res_fbv_reg    <= 1'b1;
                                    res_target_reg <= in_node;
                                    res_dest_reg   <= in_dest;
                                    res_delay_reg  <= in_delay;
                                    if (in_dest == my_id_reg)
                                        res_del_reg <= 1'b1;
                                    else
                                        state_reg <= ST_FSCAN;
                                end
                            end
                            REQ_FEEDBACK:
                            begin
                                if (in_to == my_id_reg && in_node_ok && in_dest_ok)
                                    state_reg <= ST_LRD;
                            end
                            REQ_DROP:
                            begin
                                if (in_node_ok && in_dest_ok)
                                    state_reg <= ST_LRD;
                            end
                            REQ_SEND:
                                state_reg <= ST_FSCAN;
                            default: ;
                        endcase
                    end
                end
                ST_TSCAN:
                begin
                    // drop neighbors silent for longer than the timeout
                    if (rd_vld_reg && present_reg[rd_idx_reg] && age > tmo_reg)
                        present_reg[rd_idx_reg] <= 1'b0;
                    if (scan_end)
                        state_reg <= ST_DONE;
                end
                ST_FSCAN:
                begin
                    if (rd_vld_reg)
                    begin
                        if (rd_known && (!any_reg || q_rd[COST_W-1:0] < minq_reg))
                        begin
                            minq_reg <= q_rd[COST_W-1:0];
                            any_reg  <= 1'b1;
                        end
                        if (present_reg[rd_idx_reg])
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            if (cnt_reg == '0 || rd_v < best_v_reg)
                            begin
                                best_v_reg  <= rd_v;
                                best_id_reg <= rd_idx_reg;
                            end
                        end
                    end
                    if (scan_end)
                    begin
                        res_minq_reg <= res_fbv_reg ? minq_reg : '0;
                        rem_reg      <= '0;
                        mstep_reg    <= '0;
                        if (cnt_reg == '0)
                        begin
                            res_drop_reg <= 1'b1;
                            state_reg    <= ST_DONE;
                        end
                        else if ({1'b0, re_reg} < eps_reg)
                            state_reg <= ST_MOD;
                        else
                        begin
                            res_fwd_reg <= 1'b1;
                            res_hop_reg <= ID_W'(best_id_reg);
                            state_reg   <= ST_DONE;
                        end
                    end
                end
                ST_MOD:
                begin
                    rem_reg   <= rem_next;
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 3'(ID_W - 1))
                    begin
                        k_reg        <= rem_next;
                        pick_idx_reg <= '0;
                        state_reg    <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    // walk neighbors in id order to the k-th present one
                    if (present_reg[pick_idx_reg])
                    begin
                        if (k_reg == '0)
                        begin
                            res_fwd_reg <= 1'b1;
                            res_hop_reg <= ID_W'(pick_idx_reg);
                            state_reg   <= ST_DONE;
                        end
                        else
                            k_reg <= k_reg - 1'b1;
                    end
                    pick_idx_reg <= pick_idx_reg + 1'b1;
                end
                ST_LRD:  state_reg <= ST_LMUL;
                ST_LMUL: state_reg <= ST_LWR;
                ST_LWR:  state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, res_hop_reg, res_minq_reg, res_delay_reg,
                                         res_dest_reg, res_target_reg};
                        m_tuser_reg  <= {res_drop_reg, res_fwd_reg, res_del_reg,
                                         res_fbv_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tuser[3:1]))
        else $error("more than one of delivered, forwarded, dropped");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |-> (k_reg < cnt_reg))
        else $error("pick index beyond neighbor count");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        q_busy |-> !qreq.wr_en && !accept)
        else $error("table access during clearing pass");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_issue |=> (scan_cnt_reg <= NN_SC) && rd_vld_reg)
        else $error("scan ran past the table");

endmodule
